// ===== hdl/blg_pkg.sv =====
// ----------------------------------------------------------------------------
// blg_pkg
// Shared types and constants of the Bresenham line generator.
// ----------------------------------------------------------------------------
package blg_pkg;

    localparam int COORD_BITS    = 16;
    localparam int FOLD_BITS     = COORD_BITS + 1;
    localparam int DEC_BITS      = COORD_BITS + 4;
    localparam int DIM_BITS      = 15;
    localparam int CMP_BITS      = (FOLD_BITS > DIM_BITS) ? FOLD_BITS : DIM_BITS;
    localparam int QUEUE_DEPTH   = 2;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(1024);
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(768);

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode                       opcode;
        logic signed [COORD_BITS-1:0]  start_x;
        logic signed [COORD_BITS-1:0]  start_y;
        logic signed [COORD_BITS-1:0]  end_x;
        logic signed [COORD_BITS-1:0]  end_y;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  pixel_x;
        logic signed [COORD_BITS-1:0]  pixel_y;
        logic                          pixel_valid;
        logic                          in_bounds;
        logic                          last_pixel;
    } t_out_item;

    typedef struct packed {
        t_opcode                       opcode;
        logic signed [FOLD_BITS-1:0]   major_pos;
        logic signed [FOLD_BITS-1:0]   minor_pos;
        logic signed [FOLD_BITS-1:0]   major_end;
        logic        [FOLD_BITS-1:0]   span_major;
        logic        [FOLD_BITS-1:0]   span_minor;
        logic                          swapped;
        logic                          neg_x;
        logic                          neg_y;
    } t_cmd;

endpackage

// ===== hdl/blg_front.sv =====
// ----------------------------------------------------------------------------
// blg_front
// Classify an incoming item's octant and fold the item into the first octant.
// ----------------------------------------------------------------------------
module blg_front
    import blg_pkg::*;
(
    input  t_in_item i_item,
    output t_cmd     o_cmd
);

    logic signed [FOLD_BITS-1:0] ax, ay, bx, by;
    logic signed [FOLD_BITS-1:0] dxr, dyr;
    logic        [FOLD_BITS-1:0] adx, ady;
    logic signed [FOLD_BITS-1:0] fax, fay, fbx, fby;
    logic                        neg_x, neg_y, swapped;

    always_comb begin
        ax = {i_item.start_x[COORD_BITS-1], i_item.start_x};
        ay = {i_item.start_y[COORD_BITS-1], i_item.start_y};
        bx = {i_item.end_x[COORD_BITS-1], i_item.end_x};
        by = {i_item.end_y[COORD_BITS-1], i_item.end_y};

        dxr = bx - ax;
        dyr = by - ay;
        adx = dxr[FOLD_BITS-1] ? unsigned'(-dxr) : unsigned'(dxr);
        ady = dyr[FOLD_BITS-1] ? unsigned'(-dyr) : unsigned'(dyr);

        neg_x   = !(bx > ax);
        neg_y   = !(by > ay);
        swapped = adx < ady;

        fax = neg_x ? -ax : ax;
        fbx = neg_x ? -bx : bx;
        fay = neg_y ? -ay : ay;
        fby = neg_y ? -by : by;

        o_cmd.opcode     = i_item.opcode;
        o_cmd.major_pos  = swapped ? fay : fax;
        o_cmd.minor_pos  = swapped ? fax : fay;
        o_cmd.major_end  = swapped ? fby : fbx;
        o_cmd.span_major = swapped ? ady : adx;
        o_cmd.span_minor = swapped ? adx : ady;
        o_cmd.swapped    = swapped;
        o_cmd.neg_x      = neg_x;
        o_cmd.neg_y      = neg_y;
    end

endmodule

// ===== hdl/blg_queue.sv =====
// ----------------------------------------------------------------------------
// blg_queue
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
module blg_queue
    import blg_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    t_cmd                r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hdl/blg_back.sv =====
// ----------------------------------------------------------------------------
// blg_back
// Line state, decision update and pixel output register.
// ----------------------------------------------------------------------------
module blg_back
    import blg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [DIM_BITS-1:0] i_width,
    input  logic [DIM_BITS-1:0] i_height,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_cmd_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_data
);

    logic signed [FOLD_BITS-1:0] r_major, r_minor, r_end;
    logic signed [DEC_BITS-1:0]  r_dec, r_step_s, r_step_d;
    logic                        r_swapped, r_neg_x, r_neg_y, r_active;
    logic                        r_out_valid;
    t_out_item                   r_out;

    logic                        is_start;
    logic signed [FOLD_BITS-1:0] cur_major, cur_minor, cur_end;
    logic signed [DEC_BITS-1:0]  cur_dec, cur_step_s, cur_step_d;
    logic signed [DEC_BITS-1:0]  ld_step_s, ld_step_d, ld_dec;
    logic                        cur_swapped, cur_neg_x, cur_neg_y, cur_active;
    logic signed [FOLD_BITS-1:0] fx, fy, px, py;
    logic signed [FOLD_BITS:0]   major_inc;
    logic                        last, inb;
    t_out_item                   pixel;

    assign o_cmd_pop   = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        is_start  = (i_cmd.opcode == OP_START);
        ld_step_s = signed'({2'b00, i_cmd.span_minor, 1'b0});
        ld_step_d = signed'({2'b00, i_cmd.span_minor, 1'b0})
                  - signed'({2'b00, i_cmd.span_major, 1'b0});
        ld_dec    = signed'({2'b00, i_cmd.span_minor, 1'b0})
                  - signed'({3'b000, i_cmd.span_major});

        cur_major   = is_start ? i_cmd.major_pos : r_major;
        cur_minor   = is_start ? i_cmd.minor_pos : r_minor;
        cur_end     = is_start ? i_cmd.major_end : r_end;
        cur_dec     = is_start ? ld_dec : r_dec;
        cur_step_s  = is_start ? ld_step_s : r_step_s;
        cur_step_d  = is_start ? ld_step_d : r_step_d;
        cur_swapped = is_start ? i_cmd.swapped : r_swapped;
        cur_neg_x   = is_start ? i_cmd.neg_x : r_neg_x;
        cur_neg_y   = is_start ? i_cmd.neg_y : r_neg_y;
        cur_active  = is_start ? (i_cmd.major_pos < i_cmd.major_end) : r_active;

        fx = cur_swapped ? cur_minor : cur_major;
        fy = cur_swapped ? cur_major : cur_minor;
        px = cur_neg_x ? -fx : fx;
        py = cur_neg_y ? -fy : fy;

        major_inc = {cur_major[FOLD_BITS-1], cur_major} + 1'b1;
        last      = major_inc >= $signed({cur_end[FOLD_BITS-1], cur_end});
        inb       = !px[FOLD_BITS-1] && !py[FOLD_BITS-1]
                  && (CMP_BITS'(unsigned'(px)) < CMP_BITS'(i_width))
                  && (CMP_BITS'(unsigned'(py)) < CMP_BITS'(i_height));

        pixel.pixel_x     = px[COORD_BITS-1:0];
        pixel.pixel_y     = py[COORD_BITS-1:0];
        pixel.pixel_valid = 1'b1;
        pixel.in_bounds   = inb;
        pixel.last_pixel  = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_out_valid <= 1'b1;
                r_active    <= cur_active && !last;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_cmd_pop) begin
            r_out     <= cur_active ? pixel : '0;
            r_end     <= cur_end;
            r_step_s  <= cur_step_s;
            r_step_d  <= cur_step_d;
            r_swapped <= cur_swapped;
            r_neg_x   <= cur_neg_x;
            r_neg_y   <= cur_neg_y;
            if (cur_active) begin
                r_major <= major_inc[FOLD_BITS-1:0];
                if (cur_dec[DEC_BITS-1]) begin
                    r_minor <= cur_minor;
                    r_dec   <= cur_dec + cur_step_s;
                end else begin
                    r_minor <= cur_minor + 1'b1;
                    r_dec   <= cur_dec + cur_step_d;
                end
            end else begin
                r_major <= cur_major;
                r_minor <= cur_minor;
                r_dec   <= cur_dec;
            end
        end
    end

endmodule

// ===== hdl/bresenham_line_generator_top.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_generator_top
// Bresenham line generator for all octants with image bounds flagging.
// ----------------------------------------------------------------------------
// An item is written into the command queue; the back takes it from the queue
// when its output register is free and registers the result there.
// Throughput: one item per cycle while the output is not stalled, one result
// per item; the back's decision update and pixel register set the rate.
// Reset: image size returns to 1024 x 768, no line is loaded, queue empties.
// ----------------------------------------------------------------------------
module bresenham_line_generator_top
    import blg_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
)
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_item                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_item                o_out_data,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    logic [DIM_BITS-1:0] r_width, r_height;
    t_cmd                front_cmd, queue_cmd;
    logic                queue_full, queue_valid, queue_pop;

    assign pready     = 1'b1;
    assign o_in_ready = !queue_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_WIDTH:  r_width  <= pwdata[DIM_BITS-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_BITS-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = APB_DATA_BITS'(r_width);
            REG_HEIGHT: prdata = APB_DATA_BITS'(r_height);
            default:    prdata = '0;
        endcase
    end

    blg_front u_front (
        .i_item (i_in_data),
        .o_cmd  (front_cmd)
    );

    blg_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_data  (queue_cmd)
    );

    blg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
